### sv/qtrs_pkg.sv
// ----------------------------------------------------------------------------
// qtrs_pkg
// types and constants shared by the trs matrix composer
// ----------------------------------------------------------------------------
package qtrs_pkg;

    // one request: translation, unit quaternion, per-axis scale
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } qtrs_item_t;

    // one matrix column
    typedef struct packed {
        logic [1:0]         column_index;
        logic signed [31:0] elem_row0;
        logic signed [31:0] elem_row1;
        logic signed [31:0] elem_row2;
        logic signed [31:0] elem_row3;
        logic               last_column;
    } qtrs_result_t;

    localparam int unsigned NUM_COLS = 4;
    localparam int unsigned NUM_ROWS = 3;
    localparam logic [1:0]  FIRST_COL = 2'd0;
    localparam logic [1:0]  LAST_COL  = 2'd3;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### sv/quaternion_trs_compose.sv
// ----------------------------------------------------------------------------
// quaternion_trs_compose
// column-major 4x4 transform T * R(q) * S from translation, quaternion, scale
// ----------------------------------------------------------------------------
// a request's matrix is registered through the stages before column 0 is offered;
//   columns 1-3 follow in order, each stepping on when the result side does not stall
// the single result channel carries four columns per request and so sets the
//   request rate; the pipeline holds up to 5 requests
// reset: rst_n clears all valid bits and the column counter; data is unreset
module quaternion_trs_compose
    import qtrs_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  qtrs_item_t   item,
    output logic         result_valid,
    input  logic         result_stall,
    output qtrs_result_t result
);

    // 1.0 in the fixed-point format
    localparam logic signed [63:0] ONE_WIDE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] ONE_ELEM = 32'sd1 <<< FRAC_BITS;

    // ------------------------------------------------------------------
    // stage enables: a stage moves when it is empty or the next one moves
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ser_valid_reg, ser_valid_next;
    logic [1:0] col_cnt_reg, col_cnt_next;
    logic en0, en1, en2, en3, en4;

    // serializer takes a new matrix when empty or on the accepted last column
    assign en4 = !ser_valid_reg || (!result_stall && (col_cnt_reg == LAST_COL));
    assign en3 = !v4_reg || en4;
    assign en2 = !v3_reg || en3;
    assign en1 = !v2_reg || en2;
    assign en0 = !v1_reg || en1;
    assign item_stall = !en0;

    // ------------------------------------------------------------------
    // stage 1: register the request
    // ------------------------------------------------------------------
    qtrs_item_t in_reg;

    always_ff @(posedge clk)
    begin
        if (en0 && item_valid)
        begin
            in_reg <= item;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: the nine quaternion products, kept at full width
    // ------------------------------------------------------------------
    logic signed [63:0] p_xx_reg, p_xy_reg, p_xz_reg;
    logic signed [63:0] p_yy_reg, p_yz_reg, p_zz_reg;
    logic signed [63:0] p_wx_reg, p_wy_reg, p_wz_reg;
    logic signed [31:0] pos2_reg [NUM_ROWS];
    logic signed [31:0] scl2_reg [NUM_ROWS];

    always_ff @(posedge clk)
    begin
        if (en1 && v1_reg)
        begin
            p_xx_reg <= 64'(in_reg.quat_x) * 64'(in_reg.quat_x);
            p_xy_reg <= 64'(in_reg.quat_x) * 64'(in_reg.quat_y);
            p_xz_reg <= 64'(in_reg.quat_x) * 64'(in_reg.quat_z);
            p_yy_reg <= 64'(in_reg.quat_y) * 64'(in_reg.quat_y);
            p_yz_reg <= 64'(in_reg.quat_y) * 64'(in_reg.quat_z);
            p_zz_reg <= 64'(in_reg.quat_z) * 64'(in_reg.quat_z);
            p_wx_reg <= 64'(in_reg.quat_w) * 64'(in_reg.quat_x);
            p_wy_reg <= 64'(in_reg.quat_w) * 64'(in_reg.quat_y);
            p_wz_reg <= 64'(in_reg.quat_w) * 64'(in_reg.quat_z);
            pos2_reg[0] <= in_reg.pos_x;
            pos2_reg[1] <= in_reg.pos_y;
            pos2_reg[2] <= in_reg.pos_z;
            scl2_reg[0] <= in_reg.scale_x;
            scl2_reg[1] <= in_reg.scale_y;
            scl2_reg[2] <= in_reg.scale_z;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: doubled products rescaled and clamped, rotation entries
    // ------------------------------------------------------------------
    logic signed [31:0] d_xx, d_xy, d_xz, d_yy, d_yz, d_zz, d_wx, d_wy, d_wz;
    logic signed [31:0] rot_next [NUM_ROWS][NUM_ROWS];
    logic signed [31:0] rot_reg  [NUM_ROWS][NUM_ROWS];
    logic signed [31:0] pos3_reg [NUM_ROWS];
    logic signed [31:0] scl3_reg [NUM_ROWS];

    // shifting by one bit less doubles the product
    assign d_xx = sat32(p_xx_reg >>> (FRAC_BITS - 1));
    assign d_xy = sat32(p_xy_reg >>> (FRAC_BITS - 1));
    assign d_xz = sat32(p_xz_reg >>> (FRAC_BITS - 1));
    assign d_yy = sat32(p_yy_reg >>> (FRAC_BITS - 1));
    assign d_yz = sat32(p_yz_reg >>> (FRAC_BITS - 1));
    assign d_zz = sat32(p_zz_reg >>> (FRAC_BITS - 1));
    assign d_wx = sat32(p_wx_reg >>> (FRAC_BITS - 1));
    assign d_wy = sat32(p_wy_reg >>> (FRAC_BITS - 1));
    assign d_wz = sat32(p_wz_reg >>> (FRAC_BITS - 1));

    // rot_next[column][row]
    always_comb
    begin
        rot_next[0][0] = sat32(ONE_WIDE - (64'(d_yy) + 64'(d_zz)));
        rot_next[0][1] = sat32(64'(d_xy) + 64'(d_wz));
        rot_next[0][2] = sat32(64'(d_xz) - 64'(d_wy));
        rot_next[1][0] = sat32(64'(d_xy) - 64'(d_wz));
        rot_next[1][1] = sat32(ONE_WIDE - (64'(d_xx) + 64'(d_zz)));
        rot_next[1][2] = sat32(64'(d_yz) + 64'(d_wx));
        rot_next[2][0] = sat32(64'(d_xz) + 64'(d_wy));
        rot_next[2][1] = sat32(64'(d_yz) - 64'(d_wx));
        rot_next[2][2] = sat32(ONE_WIDE - (64'(d_xx) + 64'(d_yy)));
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v2_reg)
        begin
            rot_reg  <= rot_next;
            pos3_reg <= pos2_reg;
            scl3_reg <= scl2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: each rotation column times its axis scale
    // ------------------------------------------------------------------
    logic signed [63:0] mul_reg  [NUM_ROWS][NUM_ROWS];
    logic signed [31:0] pos4_reg [NUM_ROWS];

    always_ff @(posedge clk)
    begin
        if (en3 && v3_reg)
        begin
            for (int c = 0; c < NUM_ROWS; c++)
            begin
                for (int r = 0; r < NUM_ROWS; r++)
                begin
                    mul_reg[c][r] <= 64'(rot_reg[c][r]) * 64'(scl3_reg[c]);
                end
            end
            pos4_reg <= pos3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: rescale, clamp and hold the matrix while columns go out
    // ------------------------------------------------------------------
    logic signed [31:0] mat_reg [NUM_COLS][NUM_ROWS];

    always_ff @(posedge clk)
    begin
        if (en4 && v4_reg)
        begin
            for (int c = 0; c < NUM_ROWS; c++)
            begin
                for (int r = 0; r < NUM_ROWS; r++)
                begin
                    mat_reg[c][r] <= sat32(mul_reg[c][r] >>> FRAC_BITS);
                end
            end
            // translation column passes through
            mat_reg[NUM_COLS - 1] <= pos4_reg;
        end
    end

    // column counter: restarts on a new matrix, steps on each accepted column
    always_comb
    begin
        ser_valid_next = ser_valid_reg;
        col_cnt_next   = col_cnt_reg;
        if (en4)
        begin
            ser_valid_next = v4_reg;
            col_cnt_next   = FIRST_COL;
        end
        else if (!result_stall)
        begin
            col_cnt_next = col_cnt_reg + 2'd1;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            ser_valid_reg <= 1'b0;
            col_cnt_reg   <= FIRST_COL;
        end
        else
        begin
            if (en0)
            begin
                v1_reg <= item_valid;
            end
            if (en1)
            begin
                v2_reg <= v1_reg;
            end
            if (en2)
            begin
                v3_reg <= v2_reg;
            end
            if (en3)
            begin
                v4_reg <= v3_reg;
            end
            ser_valid_reg <= ser_valid_next;
            col_cnt_reg   <= col_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // result: the column picked by the counter, row 3 is 0 or 1.0
    // ------------------------------------------------------------------
    assign result_valid        = ser_valid_reg;
    assign result.column_index = col_cnt_reg;
    assign result.elem_row0    = mat_reg[col_cnt_reg][0];
    assign result.elem_row1    = mat_reg[col_cnt_reg][1];
    assign result.elem_row2    = mat_reg[col_cnt_reg][2];
    assign result.elem_row3    = (col_cnt_reg == LAST_COL) ? ONE_ELEM : 32'sd0;
    assign result.last_column  = (col_cnt_reg == LAST_COL);

`ifndef NO_ASSERTIONS
    // an accepted column other than the last is followed by the next column
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && (result.column_index != LAST_COL))
        |=> (result_valid && (result.column_index == 2'($past(result.column_index) + 2'd1))))
    else $error("column sequence broken");

    // results only end after the last column of a matrix
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_valid) |-> $past(result.last_column))
    else $error("matrix output cut short");

    // an empty input stage never stalls a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> !item_stall)
    else $error("stall with empty input stage");
`endif

endmodule

### verif/qtrs_column_checker.sv
// ----------------------------------------------------------------------------
// qtrs_column_checker
// watches both channels of the trs matrix composer, predicts the four
// columns of every accepted request and compares them in order
// ----------------------------------------------------------------------------
module qtrs_column_checker
    import qtrs_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  logic         item_stall,
    input  qtrs_item_t   item,
    input  logic         result_valid,
    input  logic         result_stall,
    input  qtrs_result_t result,
    output int           fail_count,
    output int           outstanding,
    output int           items_seen,
    output int           columns_seen
);

    localparam logic signed [63:0] ONE_FIX = 64'sd1 << FRAC_BITS;

    qtrs_result_t pending_columns[$];
    qtrs_result_t want_col;

    initial
    begin
        fail_count   = 0;
        outstanding  = 0;
        items_seen   = 0;
        columns_seen = 0;
    end

    // keep the value when the top 33 bits agree, else clamp by sign
    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v[63:31] == {33{v[63]}})
        begin
            r = v[31:0];
        end
        else
        begin
            r = v[63] ? 32'sh80000000 : 32'sh7fffffff;
        end
        return r;
    endfunction

    // (2*a*b) >> F, floor, clamped
    function automatic logic signed [31:0] doubled_prod(input logic signed [31:0] a,
                                                        input logic signed [31:0] b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] p;
        wa = a;
        wb = b;
        p  = wa * wb;
        return clamp32(p >>> (FRAC_BITS - 1));
    endfunction

    // (a*b) >> F, floor, clamped
    function automatic logic signed [31:0] scaled_prod(input logic signed [31:0] a,
                                                       input logic signed [31:0] b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] p;
        wa = a;
        wb = b;
        p  = wa * wb;
        return clamp32(p >>> FRAC_BITS);
    endfunction

    task automatic predict_transform(input qtrs_item_t r);
        logic signed [31:0] xx, xy, xz, yy, yz, zz, wx, wy, wz;
        logic signed [31:0] rot [3][3];
        logic signed [31:0] scl [3];
        qtrs_result_t       c;
        int                 k;
        xx = doubled_prod(r.quat_x, r.quat_x);
        xy = doubled_prod(r.quat_x, r.quat_y);
        xz = doubled_prod(r.quat_x, r.quat_z);
        yy = doubled_prod(r.quat_y, r.quat_y);
        yz = doubled_prod(r.quat_y, r.quat_z);
        zz = doubled_prod(r.quat_z, r.quat_z);
        wx = doubled_prod(r.quat_w, r.quat_x);
        wy = doubled_prod(r.quat_w, r.quat_y);
        wz = doubled_prod(r.quat_w, r.quat_z);
        // rot[column][row]
        rot[0][0] = clamp32(ONE_FIX - (64'(yy) + 64'(zz)));
        rot[0][1] = clamp32(64'(xy) + 64'(wz));
        rot[0][2] = clamp32(64'(xz) - 64'(wy));
        rot[1][0] = clamp32(64'(xy) - 64'(wz));
        rot[1][1] = clamp32(ONE_FIX - (64'(xx) + 64'(zz)));
        rot[1][2] = clamp32(64'(yz) + 64'(wx));
        rot[2][0] = clamp32(64'(xz) + 64'(wy));
        rot[2][1] = clamp32(64'(yz) - 64'(wx));
        rot[2][2] = clamp32(ONE_FIX - (64'(xx) + 64'(yy)));
        scl[0] = r.scale_x;
        scl[1] = r.scale_y;
        scl[2] = r.scale_z;
        for (k = 0; k < 3; k++)
        begin
            c.column_index = k[1:0];
            c.elem_row0    = scaled_prod(rot[k][0], scl[k]);
            c.elem_row1    = scaled_prod(rot[k][1], scl[k]);
            c.elem_row2    = scaled_prod(rot[k][2], scl[k]);
            c.elem_row3    = '0;
            c.last_column  = 1'b0;
            pending_columns.push_back(c);
        end
        c.column_index = LAST_COL;
        c.elem_row0    = r.pos_x;
        c.elem_row1    = r.pos_y;
        c.elem_row2    = r.pos_z;
        c.elem_row3    = ONE_FIX[31:0];
        c.last_column  = 1'b1;
        pending_columns.push_back(c);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at column %0d: %s got %08h want %08h",
                 columns_seen, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_columns.delete();
            outstanding = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_columns.size() == 0)
                begin
                    report_mismatch("column with no request", 32'(result.column_index), 0);
                end
                else
                begin
                    want_col = pending_columns.pop_front();
                    if (result.column_index !== want_col.column_index)
                        report_mismatch("column_index", 32'(result.column_index),
                                        32'(want_col.column_index));
                    if (result.elem_row0 !== want_col.elem_row0)
                        report_mismatch("elem_row0", result.elem_row0, want_col.elem_row0);
                    if (result.elem_row1 !== want_col.elem_row1)
                        report_mismatch("elem_row1", result.elem_row1, want_col.elem_row1);
                    if (result.elem_row2 !== want_col.elem_row2)
                        report_mismatch("elem_row2", result.elem_row2, want_col.elem_row2);
                    if (result.elem_row3 !== want_col.elem_row3)
                        report_mismatch("elem_row3", result.elem_row3, want_col.elem_row3);
                    if (result.last_column !== want_col.last_column)
                        report_mismatch("last_column", 32'(result.last_column),
                                        32'(want_col.last_column));
                end
                columns_seen++;
            end
            if (item_valid && !item_stall)
            begin
                predict_transform(item);
                items_seen++;
            end
            outstanding = pending_columns.size();
        end
    end

endmodule

### verif/tb_quaternion_trs_compose.sv
// ----------------------------------------------------------------------------
// tb_quaternion_trs_compose
// drives translation / quaternion / scale requests into the trs composer
// with bursty input, patterned output stalls and one long output hold-off;
// a checker beside the block predicts every column and counts mismatches
// ----------------------------------------------------------------------------
module tb_quaternion_trs_compose;
    import qtrs_pkg::*;

    localparam int unsigned FRAC_BITS = 16;

    // run shape
    localparam int N_RANDOM    = 280;
    localparam int HOLD_CYCLES = 400;
    // longest legal quiet stretch is the hold-off; leave a wide margin
    localparam int IDLE_LIMIT  = 4000;

    // handy fixed point values
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] HALF_SQRT2 = 32'sd46341;   // cos 45 deg
    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_stall;
    qtrs_item_t   item;
    logic         result_valid;
    logic         result_stall;
    qtrs_result_t result;

    int fail_count;
    int outstanding;
    int items_seen;
    int columns_seen;

    // sender burst bookkeeping
    int burst_left;
    // long hold-off request from the stimulus to the receiver
    bit hold_off_go;
    bit hold_off_done;
    // watchdog and coverage counters
    int idle_cycles;
    int input_stalled_cycles;

    quaternion_trs_compose #(
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    qtrs_column_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .items_seen   (items_seen),
        .columns_seen (columns_seen)
    );

    // 12 unit clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // request builders
    // ------------------------------------------------------------------

    function automatic qtrs_item_t make_request(
        input logic signed [31:0] px, input logic signed [31:0] py,
        input logic signed [31:0] pz, input logic signed [31:0] qx,
        input logic signed [31:0] qy, input logic signed [31:0] qz,
        input logic signed [31:0] qw, input logic signed [31:0] sx,
        input logic signed [31:0] sy, input logic signed [31:0] sz);
        qtrs_item_t r;
        r.pos_x   = px;
        r.pos_y   = py;
        r.pos_z   = pz;
        r.quat_x  = qx;
        r.quat_y  = qy;
        r.quat_z  = qz;
        r.quat_w  = qw;
        r.scale_x = sx;
        r.scale_y = sy;
        r.scale_z = sz;
        return r;
    endfunction

    // field value biased toward the corners of the range
    function automatic logic signed [31:0] edge_word();
        logic signed [31:0] v;
        case ($urandom_range(0, 7))
            0: v = MAXV;
            1: v = MINV;
            2: v = '0;
            3: v = ONE;
            4: v = -ONE;
            5: v = 32'sd1;
            6: v = -32'sd1;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // mostly proper unit quaternions with sane scales, plus raw noise
    // and corner-heavy requests that push the saturation paths
    function automatic qtrs_item_t random_request();
        qtrs_item_t r;
        real        a, b, c, d, n;
        int         kind;
        kind = $urandom_range(0, 99);
        if (kind < 60)
        begin
            a = real'(int'($urandom_range(0, 2000)) - 1000);
            b = real'(int'($urandom_range(0, 2000)) - 1000);
            c = real'(int'($urandom_range(0, 2000)) - 1000);
            d = real'(int'($urandom_range(0, 2000)) - 1000);
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n == 0.0)
            begin
                d = 1.0;
                n = 1.0;
            end
            r.pos_x   = $urandom();
            r.pos_y   = $urandom();
            r.pos_z   = $urandom();
            r.quat_x  = $rtoi(a / n * 65536.0);
            r.quat_y  = $rtoi(b / n * 65536.0);
            r.quat_z  = $rtoi(c / n * 65536.0);
            r.quat_w  = $rtoi(d / n * 65536.0);
            // scales within +-8.0
            r.scale_x = int'($urandom_range(0, 1048576)) - 524288;
            r.scale_y = int'($urandom_range(0, 1048576)) - 524288;
            r.scale_z = int'($urandom_range(0, 1048576)) - 524288;
        end
        else if (kind < 85)
        begin
            // full 32-bit noise in every field, every bit toggles
            r = make_request($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        end
        else
        begin
            r = make_request(edge_word(), edge_word(), edge_word(), edge_word(),
                             edge_word(), edge_word(), edge_word(), edge_word(),
                             edge_word(), edge_word());
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sender side: inputs change on the falling edge only
    // ------------------------------------------------------------------

    // hold one request until the block takes it
    task automatic send_request(input qtrs_item_t req);
        @(negedge clk);
        item       <= req;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // drop valid for a gap of length n, junk on the payload to show it is ignored
    task automatic idle_gap(input int n);
        @(negedge clk);
        item_valid <= 1'b0;
        item       <= random_request();
        repeat (n - 1) @(negedge clk);
    endtask

    // bursts of random length separated by random gaps; some bursts run long
    task automatic offer(input qtrs_item_t req);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 10);
            if (gap > 0)
                idle_gap(gap);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        send_request(req);
    endtask

    // corners, each axis rotation, non-unit quaternions, odd scales
    task automatic directed_requests();
        // identity rotation, unit scale
        offer(make_request(3 * ONE, -5 * ONE, 32'sd7, 0, 0, 0, ONE, ONE, ONE, ONE));
        // everything zero
        offer(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // every field at the top or bottom of the range, then a mix that includes a zero
        offer(make_request(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
        offer(make_request(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
        offer(make_request(MAXV, MINV, 0, MINV, MAXV, MINV, MAXV, MAXV, MINV, MAXV));
        // quarter turns about x, y and z
        offer(make_request(ONE, 0, 0, HALF_SQRT2, 0, 0, HALF_SQRT2, 2 * ONE, ONE, -ONE));
        offer(make_request(0, ONE, 0, 0, HALF_SQRT2, 0, HALF_SQRT2, ONE, 3 * ONE, ONE));
        offer(make_request(0, 0, ONE, 0, 0, HALF_SQRT2, HALF_SQRT2, ONE, ONE, ONE / 2));
        // half turns about each axis
        offer(make_request(-ONE, 0, 0, ONE, 0, 0, 0, ONE, ONE, ONE));
        offer(make_request(0, -ONE, 0, 0, ONE, 0, 0, ONE, ONE, ONE));
        offer(make_request(0, 0, -ONE, 0, 0, ONE, 0, ONE, ONE, ONE));
        // negated scalar part, same rotation as identity
        offer(make_request(0, 0, 0, 0, 0, 0, -ONE, ONE, ONE, ONE));
        // non-unit quaternion, applied as is with clamping
        offer(make_request(0, 0, 0, 2 * ONE, 3 * ONE, -4 * ONE, 5 * ONE, ONE, ONE, ONE));
        offer(make_request(0, 0, 0, 200 * ONE, -300 * ONE, 400 * ONE, 500 * ONE,
                           MAXV, MINV, MAXV));
        // zero and negative scales
        offer(make_request(ONE, ONE, ONE, HALF_SQRT2, 0, HALF_SQRT2, 0, 0, 0, 0));
        offer(make_request(ONE, ONE, ONE, 0, HALF_SQRT2, 0, HALF_SQRT2,
                           -3 * ONE, -3 * ONE, -3 * ONE));
        // smallest magnitudes, floor on negative products
        offer(make_request(32'sd1, -32'sd1, 0, 32'sd1, -32'sd1, 32'sd1, -32'sd1,
                           -32'sd1, 32'sd1, -32'sd1));
        // huge scale on identity, then max quaternion with min scale
        offer(make_request(0, 0, 0, 0, 0, 0, ONE, MAXV, MAXV, MINV));
        offer(make_request(0, 0, 0, MAXV, 0, 0, MAXV, MINV, MINV, MINV));
    endtask

    // ------------------------------------------------------------------
    // receiver side: the stall pattern is redrawn at random among free, light, heavy
    // and periodic modes, plus one long hold-off that fills the pipeline
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int mode;
        int mode_left;
        int phase;
        result_stall  = 1'b0;
        hold_off_done = 1'b0;
        mode          = 0;
        mode_left     = 0;
        phase         = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_go && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                result_stall <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                phase++;
                case (mode)
                    0: result_stall <= 1'b0;                          // free flow
                    1: result_stall <= ($urandom_range(0, 99) < 30);  // light
                    2: result_stall <= ($urandom_range(0, 99) < 70);  // heavy
                    default: result_stall <= (phase % 5) < 2;         // periodic
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: cycles with no accept on either channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_stall)
                input_stalled_cycles <= input_stalled_cycles + 1;
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles == IDLE_LIMIT)
            begin
                $display("timeout after %0d quiet cycles, %0d columns still due",
                         idle_cycles, outstanding);
                $display("[quaternion_trs_compose] ERROR");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int n;
        rst_n                = 1'b0;
        item_valid           = 1'b0;
        item                 = '0;
        hold_off_go          = 1'b0;
        burst_left           = 0;
        idle_cycles          = 0;
        input_stalled_cycles = 0;

        // reset held low from the start, released on a falling edge
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        directed_requests();

        for (n = 0; n < N_RANDOM; n++)
        begin
            // a third of the way in, hold the result side off for a long stretch
            if (n == N_RANDOM / 3)
                hold_off_go = 1'b1;
            offer(random_request());
        end

        @(negedge clk);
        item_valid <= 1'b0;

        // drain, then keep running to catch anything extra
        while (outstanding != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("covered %0d transforms (%0d columns) incl. axis turns, corners, noise",
                 items_seen, columns_seen);
        $display("input held back %0d cycles, one %0d-cycle result hold-off, %0d mismatches",
                 input_stalled_cycles, HOLD_CYCLES, fail_count);
        if (fail_count == 0)
        begin
            $display("[quaternion_trs_compose] OK");
        end
        else
        begin
            $display("[quaternion_trs_compose] ERROR");
        end
        $finish;
    end

endmodule
